FILE: src/pcm_pkg.sv
// shared widths, types and constants of the projective coordinate mapper
package pcm_pkg;

    // internal accumulator width at the 2^-28 scale, covers coordinates up to 16 bits
    localparam int ACC_W = 51;
    // quotient bits produced by the divider: 32 integer and 17 fraction
    localparam int QBITS = 49;
    // fraction bits of the quotient beyond the integer part
    localparam int FRAC_BITS = 17;
    // integer bits of the quotient
    localparam int INT_BITS = 32;

    // register indexes of the configuration port
    localparam logic [2:0] REG_XX_XY = 3'd0;
    localparam logic [2:0] REG_XO_YX = 3'd1;
    localparam logic [2:0] REG_YY_YO = 3'd2;
    localparam logic [2:0] REG_PX_PY = 3'd3;
    localparam logic [2:0] REG_PW    = 3'd4;

    // reset values
    localparam logic [63:0] RST_XX_XY = 64'h1000_0000_0000_0000;
    localparam logic [63:0] RST_XO_YX = 64'h0;
    localparam logic [63:0] RST_YY_YO = 64'h1000_0000_0000_0000;
    localparam logic [63:0] RST_PX_PY = 64'h0;
    localparam logic [31:0] RST_PW    = 32'h1000_0000;

    // w of one at the internal scale
    localparam logic [ACC_W-1:0] ONE_Q28 = ACC_W'(64'h1000_0000);

    // saturation limits of the quotient magnitude
    localparam logic [QBITS-1:0] SAT_POS = QBITS'(64'h7FFF_FFFF);
    localparam logic [QBITS-1:0] SAT_NEG = QBITS'(64'h8000_0000);

    // per item flags that travel beside the divider
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic big_x;
        logic big_y;
        logic wz;
    } side_t;

endpackage

FILE: src/pcm_divider.sv
// pipelined restoring divider, one quotient bit per stage
module pcm_divider
    import pcm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [ACC_W-1:0] num,
    input  logic [ACC_W-1:0] den,
    output logic [QBITS-1:0] quot
);

    logic [ACC_W-1:0] r_reg   [1:QBITS];
    logic [QBITS-1:0] dq_reg  [1:QBITS];
    logic [ACC_W-1:0] den_reg [1:QBITS];

    logic [ACC_W-1:0] r_in   [0:QBITS-1];
    logic [QBITS-1:0] dq_in  [0:QBITS-1];
    logic [ACC_W-1:0] den_in [0:QBITS-1];

    // first partial remainder is the integer part above the quotient range
    assign r_in[0]   = ACC_W'(num[ACC_W-1:INT_BITS]);
    assign dq_in[0]  = {num[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
    assign den_in[0] = den;

    genvar k;
    generate
        for (k = 1; k <= QBITS; k++)
        begin : g_stage
            logic [ACC_W:0]   r2;
            logic             ge;
            logic [ACC_W-1:0] r_next;
            logic [QBITS-1:0] dq_next;

            // shift in next dividend bit, compare and subtract
            assign r2      = {r_in[k-1], dq_in[k-1][QBITS-1]};
            assign ge      = (r2 >= {1'b0, den_in[k-1]});
            assign r_next  = ge ? ACC_W'(r2 - {1'b0, den_in[k-1]}) : r2[ACC_W-1:0];
            assign dq_next = {dq_in[k-1][QBITS-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]   <= r_next;
                    dq_reg[k]  <= dq_next;
                    den_reg[k] <= den_in[k-1];
                end
            end

            if (k < QBITS)
            begin : g_link
                assign r_in[k]   = r_reg[k];
                assign dq_in[k]  = dq_reg[k];
                assign den_in[k] = den_reg[k];
            end
        end
    endgenerate

    // remainder and divisor of the last stage are not needed further
    logic unused_tail;
    assign unused_tail = ^{r_reg[QBITS], den_reg[QBITS]};

    assign quot = dq_reg[QBITS];

endmodule

FILE: src/projective_coordinate_mapper.sv
// projective coordinate mapper top level: 3x3 homography with rounded divide
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, dest_x, dest_y        | request in
//  out     | out_valid, out_ready, source_x, source_y, | request out
//          | w_zero, clipped                           |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | write in
//
// one request per cycle sustained while the output is not stalled; the stages are products, sums,
// magnitudes, 49 divider stages (one quotient bit each) and the output register.
// reset returns the coefficients to the identity map and empties the pipeline.
// a stalled output freezes the whole pipeline; no request is lost or repeated.
// config writes are always taken; indexes beyond the list are ignored.
module projective_coordinate_mapper
    import pcm_pkg::*;
#(
    parameter int COORD_BITS = 13
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [12:0]        dest_x,
    input  logic [12:0]        dest_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] source_x,
    output logic signed [31:0] source_y,
    output logic               w_zero,
    output logic               clipped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int PW = COORD_BITS + 33;
    localparam int LAT = QBITS + 3;

    logic [63:0] xx_xy_reg, xo_yx_reg, yy_yo_reg, px_py_reg;
    logic [31:0] pw_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_xy_reg <= RST_XX_XY;
            xo_yx_reg <= RST_XO_YX;
            yy_yo_reg <= RST_YY_YO;
            px_py_reg <= RST_PX_PY;
            pw_reg    <= RST_PW;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_XX_XY: xx_xy_reg <= cfg_data;
                REG_XO_YX: xo_yx_reg <= cfg_data;
                REG_YY_YO: yy_yo_reg <= cfg_data;
                REG_PX_PY: px_py_reg <= cfg_data;
                REG_PW:    pw_reg    <= cfg_data[31:0];
                default:   ;
            endcase
        end
    end

    // global advance: move unless a result is waiting
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    logic [LAT-1:0] v_reg;

    // coordinates, low COORD_BITS bits only
    logic [15:0]           dx16, dy16;
    logic [COORD_BITS:0]   xs, ys;
    assign dx16 = {3'b000, dest_x};
    assign dy16 = {3'b000, dest_y};
    assign xs   = {1'b0, dx16[COORD_BITS-1:0]};
    assign ys   = {1'b0, dy16[COORD_BITS-1:0]};

    // stage 1: six products
    logic signed [PW-1:0] pxx, pxy, pyx, pyy, ppx, ppy;
    logic signed [PW-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg, ppx_reg, ppy_reg;
    logic signed [31:0]   xo_s1_reg, yo_s1_reg, pw_s1_reg;
    assign pxx = $signed(xx_xy_reg[63:32]) * $signed(xs);
    assign pxy = $signed(xx_xy_reg[31:0])  * $signed(ys);
    assign pyx = $signed(xo_yx_reg[31:0])  * $signed(xs);
    assign pyy = $signed(yy_yo_reg[63:32]) * $signed(ys);
    assign ppx = $signed(px_py_reg[63:32]) * $signed(xs);
    assign ppy = $signed(px_py_reg[31:0])  * $signed(ys);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg   <= pxx;
            pxy_reg   <= pxy;
            pyx_reg   <= pyx;
            pyy_reg   <= pyy;
            ppx_reg   <= ppx;
            ppy_reg   <= ppy;
            xo_s1_reg <= $signed(xo_yx_reg[63:32]);
            yo_s1_reg <= $signed(yy_yo_reg[31:0]);
            pw_s1_reg <= $signed(pw_reg);
        end
    end

    // stage 2: three sums, offsets moved to the 2^-28 scale
    logic signed [ACC_W-1:0] w_next, nx_next, ny_next;
    logic signed [ACC_W-1:0] w_reg, nx_reg, ny_reg;
    assign w_next  = ACC_W'(ppx_reg) + ACC_W'(ppy_reg) + ACC_W'(pw_s1_reg);
    assign nx_next = ACC_W'(pxx_reg) + ACC_W'(pxy_reg)
                   + $signed({{(ACC_W-44){xo_s1_reg[31]}}, xo_s1_reg, 12'h000});
    assign ny_next = ACC_W'(pyx_reg) + ACC_W'(pyy_reg)
                   + $signed({{(ACC_W-44){yo_s1_reg[31]}}, yo_s1_reg, 12'h000});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg  <= w_next;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
    end

    // stage 3: zero denominator, magnitudes, signs, integer overflow check
    logic             wz;
    logic [ACC_W-1:0] wv, aw, anx, any;
    logic [ACC_W-1:0] aw_reg, anx_reg, any_reg;
    side_t            side_next;
    side_t            side_reg [0:QBITS];
    assign wz  = (w_reg == '0);
    assign wv  = wz ? ONE_Q28 : w_reg;
    assign aw  = wv[ACC_W-1] ? ACC_W'(-wv) : wv;
    assign anx = nx_reg[ACC_W-1] ? ACC_W'(-nx_reg) : nx_reg;
    assign any = ny_reg[ACC_W-1] ? ACC_W'(-ny_reg) : ny_reg;
    assign side_next.neg_x = nx_reg[ACC_W-1] != wv[ACC_W-1];
    assign side_next.neg_y = ny_reg[ACC_W-1] != wv[ACC_W-1];
    assign side_next.big_x = ACC_W'(anx[ACC_W-1:INT_BITS]) >= aw;
    assign side_next.big_y = ACC_W'(any[ACC_W-1:INT_BITS]) >= aw;
    assign side_next.wz    = wz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aw_reg      <= aw;
            anx_reg     <= anx;
            any_reg     <= any;
            side_reg[0] <= side_next;
        end
    end

    // flags ride alongside the divider stages
    genvar s;
    generate
        for (s = 1; s <= QBITS; s++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[s] <= side_reg[s-1];
            end
        end
    endgenerate

    // two dividers sharing the denominator
    logic [QBITS-1:0] qx, qy;
    pcm_divider u_div_x (.clk(clk), .en(en), .num(anx_reg), .den(aw_reg), .quot(qx));
    pcm_divider u_div_y (.clk(clk), .en(en), .num(any_reg), .den(aw_reg), .quot(qy));

    // rounding half away from zero and saturation
    logic [QBITS-1:0] mx, my, lim_x, lim_y, fx, fy;
    logic             sat_x, sat_y;
    side_t            sd;
    assign sd    = side_reg[QBITS];
    assign mx    = QBITS'(({1'b0, qx} + 1'b1) >> 1);
    assign my    = QBITS'(({1'b0, qy} + 1'b1) >> 1);
    assign lim_x = sd.neg_x ? SAT_NEG : SAT_POS;
    assign lim_y = sd.neg_y ? SAT_NEG : SAT_POS;
    assign sat_x = sd.big_x || (mx > lim_x);
    assign sat_y = sd.big_y || (my > lim_y);
    assign fx    = sat_x ? lim_x : mx;
    assign fy    = sat_y ? lim_y : my;

    logic signed [31:0] sx_reg, sy_reg;
    logic               wz_reg, clip_reg, ov_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg   <= sd.neg_x ? -$signed(fx[31:0]) : $signed(fx[31:0]);
            sy_reg   <= sd.neg_y ? -$signed(fy[31:0]) : $signed(fy[31:0]);
            wz_reg   <= sd.wz;
            clip_reg <= sat_x || sat_y;
        end
    end

    // valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[LAT-2:0], in_valid};
            ov_reg <= v_reg[LAT-1];
        end
    end

    assign out_valid = ov_reg;
    assign source_x  = sx_reg;
    assign source_y  = sy_reg;
    assign w_zero    = wz_reg;
    assign clipped   = clip_reg;

    // an accepted request enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted request missing from first stage");

    // a clipped result carries a saturated coordinate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (source_x == 32'sh7FFF_FFFF || source_x == -32'sh8000_0000 ||
             source_y == 32'sh7FFF_FFFF || source_y == -32'sh8000_0000))
        else $error("clipped without saturated output");

    // a stalled pipeline keeps its occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(v_reg))
        else $error("pipeline moved while stalled");

endmodule

FILE: bench/tb_top.sv
// testbench for the projective coordinate mapper: random and directed pixels, scoreboard check
`timescale 1ns / 100ps

module tb_top;
    import pcm_pkg::*;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
    } pixel_t;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic        wz;
        logic        clip;
    } mapped_t;

    localparam int PIPE_LAT  = 53;
    localparam int STALL_MAX = 200000;

    // index past the end of the register list, writes are dropped
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [12:0] dest_x;
    logic [12:0] dest_y;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic        w_zero;
    logic        clipped;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // shadow copy of the coefficient registers
    logic [63:0] m_xx_xy;
    logic [63:0] m_xo_yx;
    logic [63:0] m_yy_yo;
    logic [63:0] m_px_py;
    logic [31:0] m_pw;

    pixel_t  pixel_q[$];
    mapped_t mapped_q[$];
    int      mismatches = 0;
    int      stall_cycles;
    bit      calm;
    bit      cfg_busy;

    projective_coordinate_mapper dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .dest_x(dest_x), .dest_y(dest_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .source_x(source_x), .source_y(source_y), .w_zero(w_zero), .clipped(clipped),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // rounded saturated n / w in q16.16
    function automatic logic [31:0] div_q16(longint n, longint w, inout bit sat);
        logic [63:0] an;
        logic [63:0] aw;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        logic [63:0] lim;
        bit          neg;
        an  = (n < 0) ? -n : n;
        aw  = (w < 0) ? -w : w;
        neg = (n < 0) != (w < 0);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q   = an / aw;
        r   = an % aw;
        if (q >= 64'h1_0000_0000)
            m = lim + 1;
        else
        begin
            for (int i = 0; i < 17; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= aw)
                begin
                    r = r - aw;
                    q[0] = 1'b1;
                end
            end
            m = (q + 1) >> 1;
        end
        if (m > lim)
        begin
            m = lim;
            sat = 1'b1;
        end
        if (neg)
            m = -m;
        return m[31:0];
    endfunction

    // source coordinate of one destination pixel under the current matrix
    function automatic mapped_t map_pixel(pixel_t p);
        longint  x;
        longint  y;
        longint  w;
        longint  nx;
        longint  ny;
        bit      sat;
        mapped_t res;
        x   = p.x;
        y   = p.y;
        sat = 1'b0;
        w   = longint'($signed(m_px_py[63:32])) * x + longint'($signed(m_px_py[31:0])) * y
              + longint'($signed(m_pw));
        nx  = longint'($signed(m_xx_xy[63:32])) * x + longint'($signed(m_xx_xy[31:0])) * y
              + longint'($signed(m_xo_yx[63:32])) * 4096;
        ny  = longint'($signed(m_xo_yx[31:0])) * x + longint'($signed(m_yy_yo[63:32])) * y
              + longint'($signed(m_yy_yo[31:0])) * 4096;
        res.wz = (w == 0);
        if (res.wz)
            w = 64'sd268435456;
        res.sx   = div_q16(nx, w, sat);
        res.sy   = div_q16(ny, w, sat);
        res.clip = sat;
        return res;
    endfunction

    // report one mismatch
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            dest_x   <= '0;
            dest_y   <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 10))
            begin
                pixel_t p;
                p = pixel_q.pop_front();
                mapped_q.push_back(map_pixel(p));
                in_valid <= 1'b1;
                dest_x   <= p.x;
                dest_y   <= p.y;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(99) >= 10);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_busy)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (mapped_q.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    mismatches++;
                end
                else
                begin
                    mapped_t e;
                    e = mapped_q.pop_front();
                    if (source_x !== e.sx)
                        report_mismatch("source_x", source_x, e.sx);
                    if (source_y !== e.sy)
                        report_mismatch("source_y", source_y, e.sy);
                    if (w_zero !== e.wz)
                        report_mismatch("w_zero", 32'(w_zero), 32'(e.wz));
                    if (clipped !== e.clip)
                        report_mismatch("clipped", 32'(clipped), 32'(e.clip));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (stall_cycles > STALL_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one register write, block idle
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_busy = 1'b1;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_XX_XY: m_xx_xy = val;
            REG_XO_YX: m_xo_yx = val;
            REG_YY_YO: m_yy_yo = val;
            REG_PX_PY: m_px_py = val;
            REG_PW:    m_pw    = val[31:0];
            default: ;
        endcase
        cfg_busy = 1'b0;
    endtask

    task automatic drain;
        cfg_busy = 1'b0;
        while (pixel_q.size() > 0 || mapped_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // coordinates biased toward edges
    function automatic logic [12:0] pick_coord();
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'h1FFF;
            2: return 13'($urandom_range(15));
            default: return 13'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_q28();
        case ($urandom_range(7))
            0: return 32'h1000_0000;
            1: return 32'hF000_0000;
            2: return 32'h0;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return 32'($signed($urandom_range(65535)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_proj();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'($signed($urandom_range(8191)) - 4096);
            2: return 32'($signed($urandom_range(255)) - 128);
            default: return $urandom;
        endcase
    endfunction

    // random matrix, sometimes affine, sometimes tuned so w can hit zero
    task automatic random_matrix();
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pw;
        write_reg(REG_XX_XY, {pick_q28(), pick_q28()});
        write_reg(REG_XO_YX, {$urandom, pick_q28()});
        write_reg(REG_YY_YO, {pick_q28(), $urandom});
        case ($urandom_range(3))
            0:
            begin
                px = 0;
                py = 0;
                pw = 32'h1000_0000;
            end
            1:
            begin
                // w = k*(x - y) + 0, zero on the diagonal
                px = 32'($urandom_range(1000) + 1);
                py = -px;
                pw = 0;
            end
            default:
            begin
                px = pick_proj();
                py = pick_proj();
                pw = $urandom;
            end
        endcase
        write_reg(REG_PX_PY, {px, py});
        write_reg(REG_PW, {32'h0, pw});
        write_reg(REG_SPARE, {$urandom, $urandom});
    endtask

    initial
    begin
        pixel_t p;
        int     sent;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        cfg_busy  = 1'b0;
        m_xx_xy = RST_XX_XY;
        m_xo_yx = RST_XO_YX;
        m_yy_yo = RST_YY_YO;
        m_px_py = RST_PX_PY;
        m_pw    = RST_PW;
        rst_n = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity map at corners and one interior point
        pixel_q.push_back('{13'd0, 13'd0});
        pixel_q.push_back('{13'h1FFF, 13'h1FFF});
        pixel_q.push_back('{13'h1FFF, 13'd0});
        pixel_q.push_back('{13'h1555, 13'h0AAA});
        drain();

        // zero denominator
        write_reg(REG_PW, 64'h0);
        pixel_q.push_back('{13'd0, 13'd0});
        pixel_q.push_back('{13'd5, 13'd9});
        drain();

        // tiny w forces saturation both ways, rounding halves
        write_reg(REG_PW, 64'h1);
        write_reg(REG_XO_YX, {32'h0000_8000, 32'hF000_0000});
        pixel_q.push_back('{13'd1, 13'd1});
        pixel_q.push_back('{13'd0, 13'd0});
        drain();
        write_reg(REG_PW, {32'h0, 32'hFFFF_FFFF});
        write_reg(REG_XX_XY, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(REG_YY_YO, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_PX_PY, {32'h8000_0000, 32'h7FFF_FFFF});
        pixel_q.push_back('{13'h1FFF, 13'h1FFF});
        pixel_q.push_back('{13'h1FFF, 13'd0});
        pixel_q.push_back('{13'd0, 13'h1FFF});
        drain();
        // halves: pw = 2.0, numerator odd offsets
        write_reg(REG_PX_PY, 64'h0);
        write_reg(REG_PW, {32'h0, 32'h2000_0000});
        write_reg(REG_XO_YX, {32'h0000_0001, 32'h0});
        write_reg(REG_YY_YO, {32'h0, 32'hFFFF_FFFF});
        pixel_q.push_back('{13'd0, 13'd0});
        drain();

        // random phases
        sent = 0;
        while (sent < 1750)
        begin
            int n;
            random_matrix();
            n = $urandom_range(150, 40);
            calm = (sent >= 600 && sent < 900);
            for (int i = 0; i < n; i++)
            begin
                p.x = pick_coord();
                p.y = ($urandom_range(3) == 0) ? p.x : pick_coord();
                pixel_q.push_back(p);
            end
            sent += n;
            drain();
        end

        // back to reset values at the end
        write_reg(REG_XX_XY, RST_XX_XY);
        write_reg(REG_XO_YX, RST_XO_YX);
        write_reg(REG_YY_YO, RST_YY_YO);
        write_reg(REG_PX_PY, RST_PX_PY);
        write_reg(REG_PW, {32'h0, RST_PW});
        for (int i = 0; i < 20; i++)
            pixel_q.push_back('{13'($urandom), 13'($urandom)});
        drain();
        repeat (PIPE_LAT + 10)
            @(posedge clk);
        if (mismatches == 0 && mapped_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
